### rtl/pr_pkg.sv
// Package for the ranking block: sizes, register indexes, modes, word types, sequencer states.
// No dependencies; every rtl file imports it.
package pr_pkg;

    localparam int MAX_NODES  = 64;
    localparam int NODE_BITS  = 6;
    localparam int COUNT_BITS = 16;
    localparam int RANK_BITS  = 32;
    localparam int SUM_BITS   = 22;
    localparam int NUM_BITS   = COUNT_BITS + RANK_BITS;
    localparam int CFG_BITS   = 10;

    localparam logic [1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [1:0] REG_ITERATIONS = 2'd1;
    localparam logic [1:0] REG_TOP_COUNT  = 2'd2;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_ADD   = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;

    localparam logic [6:0] NODES_RESET = 7'd64;
    localparam logic [9:0] ITER_RESET  = 10'd260;
    localparam logic [6:0] TOP_RESET   = 7'd10;

    typedef struct packed {
        logic [1:0] mode;
        logic [5:0] source_node;
        logic [5:0] dest_node;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  node_index;
        logic [31:0] rank_score;
        logic        is_last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_ADD_RD,
        S_ADD_WR,
        S_CS_RD,
        S_CS_ACC,
        S_ST_DIV,
        S_ST_WR,
        S_PW_RD,
        S_PW_MUL,
        S_PW_DIV,
        S_PW_ACC,
        S_SEL_RD,
        S_SEL_CMP,
        S_SEL_OUT
    } t_state;

endpackage

### rtl/pagerank_top_n.sv
// Top level of the ranking block: edge count memory, rank memory, sequencer.
// Depends on pr_pkg and pr_div.
// Reset (synchronous, active low) starts a clearing sweep of the 4096-entry edge count
// memory, one word per cycle; busy stays high until the sweep ends. A clear word runs the
// same sweep, an add word one read and one write of a count. A run sums the columns, then
// runs the set number of power rounds of n*n terms, each a pass of the 32-step shared
// divider unless its count is zero and its column sum is not; a result word scans n ranks.
// Results leave one per strobe and cannot be stalled; one word is in work at a time.
module pagerank_top_n
    import pr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_in_item            i_item,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_data,
    output logic                o_strobe,
    output t_out_item           o_result
);

    // Configuration registers.
    logic [6:0] r_nodes;
    logic [9:0] r_iters;
    logic [6:0] r_top;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes <= NODES_RESET;
            r_iters <= ITER_RESET;
            r_top   <= TOP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_NODE_COUNT: r_nodes <= i_cfg_data[6:0];
                REG_ITERATIONS: r_iters <= i_cfg_data[9:0];
                REG_TOP_COUNT:  r_top   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Effective node count and result count after clamping.
    logic [6:0] nn;
    logic [6:0] want;
    logic [6:0] nn_m1;

    always_comb begin
        if (r_nodes == 7'd0) begin
            nn = 7'd1;
        end else if (r_nodes > 7'(MAX_NODES)) begin
            nn = 7'(MAX_NODES);
        end else begin
            nn = r_nodes;
        end
        want = (r_top == 7'd0) ? 7'd1 : r_top;
        if (want > nn) begin
            want = nn;
        end
        nn_m1 = nn - 7'd1;
    end

    // Sequencer registers.
    t_state r_state, n_state;
    logic [11:0]          r_clr, n_clr;
    logic [5:0]           r_src, n_src;
    logic [5:0]           r_dst, n_dst;
    logic [5:0]           r_row, n_row;
    logic [5:0]           r_col, n_col;
    logic [9:0]           r_iter, n_iter;
    logic                 r_bank, n_bank;
    logic [SUM_BITS-1:0]  r_csum, n_csum;
    logic [RANK_BITS-1:0] r_acc, n_acc;
    logic [RANK_BITS-1:0] r_term, n_term;
    logic [6:0]           r_k, n_k;
    logic [MAX_NODES-1:0] r_picked, n_picked;
    logic                 r_found, n_found;
    logic [5:0]           r_best_idx, n_best_idx;
    logic [RANK_BITS-1:0] r_best_val, n_best_val;
    logic                 r_strobe, n_strobe;
    t_out_item            r_result, n_result;

    // Memories and their ports.
    logic [COUNT_BITS-1:0] edge_mem [MAX_NODES*MAX_NODES];
    logic [RANK_BITS-1:0]  rank_mem [2*MAX_NODES];
    logic [SUM_BITS-1:0]   csum_mem [MAX_NODES];

    logic                  edge_we;
    logic [11:0]           edge_waddr, edge_raddr;
    logic [COUNT_BITS-1:0] edge_wdata, r_edge_q;
    logic                  rank_we;
    logic [6:0]            rank_waddr, rank_raddr;
    logic [RANK_BITS-1:0]  rank_wdata, r_rank_q;
    logic                  csum_we;
    logic [5:0]            csum_waddr, csum_raddr;
    logic [SUM_BITS-1:0]   csum_wdata, r_csum_q;

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[edge_waddr] <= edge_wdata;
        end
        r_edge_q <= edge_mem[edge_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (rank_we) begin
            rank_mem[rank_waddr] <= rank_wdata;
        end
        r_rank_q <= rank_mem[rank_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (csum_we) begin
            csum_mem[csum_waddr] <= csum_wdata;
        end
        r_csum_q <= csum_mem[csum_raddr];
    end

    // Shared divider.
    logic                 div_start;
    logic [NUM_BITS-1:0]  div_numer;
    logic [SUM_BITS-1:0]  div_denom;
    logic                 div_done;
    logic [RANK_BITS-1:0] div_quot;

    pr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    logic accept;
    logic row_last, col_last, k_last;
    logic [RANK_BITS:0] acc_sum;
    logic [RANK_BITS-1:0] acc_sat;

    assign accept   = start && !busy;
    assign row_last = ({1'b0, r_row} == nn_m1);
    assign col_last = ({1'b0, r_col} == nn_m1);
    assign k_last   = ((r_k + 7'd1) == want);
    assign acc_sum  = {1'b0, r_acc} + {1'b0, r_term};
    assign acc_sat  = acc_sum[RANK_BITS] ? {RANK_BITS{1'b1}} : acc_sum[RANK_BITS-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_item.mode)
                        MODE_CLEAR: n_state = S_CLR;
                        MODE_ADD:   n_state = S_ADD_RD;
                        MODE_RUN:   n_state = S_CS_RD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR:     n_state = (r_clr == 12'hFFF) ? S_IDLE : S_CLR;
            S_ADD_RD:  n_state = S_ADD_WR;
            S_ADD_WR:  n_state = S_IDLE;
            S_CS_RD:   n_state = S_CS_ACC;
            S_CS_ACC:  n_state = (row_last && col_last) ? S_ST_DIV : S_CS_RD;
            S_ST_DIV: begin
                if (nn == 7'd1 || div_done) begin
                    n_state = S_ST_WR;
                end
            end
            S_ST_WR: begin
                if (row_last) begin
                    n_state = (r_iter == 10'd0) ? S_SEL_RD : S_PW_RD;
                end
            end
            S_PW_RD:   n_state = S_PW_MUL;
            S_PW_MUL: begin
                if (r_csum_q != '0 && r_edge_q == '0) begin
                    n_state = S_PW_ACC;
                end else begin
                    n_state = S_PW_DIV;
                end
            end
            S_PW_DIV:  n_state = div_done ? S_PW_ACC : S_PW_DIV;
            S_PW_ACC: begin
                if (col_last && row_last && r_iter == 10'd1) begin
                    n_state = S_SEL_RD;
                end else begin
                    n_state = S_PW_RD;
                end
            end
            S_SEL_RD:  n_state = S_SEL_CMP;
            S_SEL_CMP: n_state = row_last ? S_SEL_OUT : S_SEL_RD;
            S_SEL_OUT: n_state = k_last ? S_IDLE : S_SEL_RD;
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_clr      = r_clr;
        n_src      = r_src;
        n_dst      = r_dst;
        n_row      = r_row;
        n_col      = r_col;
        n_iter     = r_iter;
        n_bank     = r_bank;
        n_csum     = r_csum;
        n_acc      = r_acc;
        n_term     = r_term;
        n_k        = r_k;
        n_picked   = r_picked;
        n_found    = r_found;
        n_best_idx = r_best_idx;
        n_best_val = r_best_val;
        n_strobe   = 1'b0;
        n_result   = r_result;

        edge_we    = 1'b0;
        edge_waddr = r_clr;
        edge_wdata = '0;
        edge_raddr = {r_row, r_col};
        rank_we    = 1'b0;
        rank_waddr = {~r_bank, r_row};
        rank_wdata = acc_sat;
        rank_raddr = {r_bank, r_col};
        csum_we    = 1'b0;
        csum_waddr = r_col;
        csum_wdata = r_csum + {{(SUM_BITS-COUNT_BITS){1'b0}}, r_edge_q};
        csum_raddr = r_col;
        div_start  = 1'b0;
        div_numer  = {{(NUM_BITS-RANK_BITS){1'b0}}, r_rank_q};
        div_denom  = {{(SUM_BITS-7){1'b0}}, nn};

        case (r_state)
            S_IDLE: begin
                n_clr  = '0;
                n_src  = i_item.source_node;
                n_dst  = i_item.dest_node;
                n_row  = '0;
                n_col  = '0;
                n_csum = '0;
                n_acc  = '0;
                n_k    = '0;
                n_bank = 1'b0;
                n_iter = r_iters;
                n_picked = '0;
                n_found  = 1'b0;
            end
            S_CLR: begin
                edge_we = 1'b1;
                n_clr   = r_clr + 12'd1;
            end
            S_ADD_RD: begin
                edge_raddr = {r_dst, r_src};
            end
            S_ADD_WR: begin
                edge_waddr = {r_dst, r_src};
                edge_wdata = r_edge_q + COUNT_BITS'(1);
                edge_we    = (r_edge_q != {COUNT_BITS{1'b1}});
            end
            S_CS_RD: ;
            S_CS_ACC: begin
                // Counts of column r_col are summed down the active rows.
                if (row_last) begin
                    csum_we = 1'b1;
                    n_csum  = '0;
                    n_row   = '0;
                    n_col   = r_col + 6'd1;
                end else begin
                    n_csum = csum_wdata;
                    n_row  = r_row + 6'd1;
                end
            end
            S_ST_DIV: begin
                n_col = '0;
                div_numer = NUM_BITS'(64'h1_0000_0000);
                div_start = (r_clr == 12'd0) && (nn != 7'd1);
                n_clr = 12'd1;
                if (nn == 7'd1) begin
                    n_term = {RANK_BITS{1'b1}};
                end else if (div_done) begin
                    n_term = div_quot;
                end
            end
            S_ST_WR: begin
                rank_we    = 1'b1;
                rank_waddr = {1'b0, r_row};
                rank_wdata = r_term;
                n_row = row_last ? 6'd0 : r_row + 6'd1;
            end
            S_PW_RD: begin
                edge_raddr = {r_row, r_col};
            end
            S_PW_MUL: begin
                if (r_csum_q != '0) begin
                    div_numer = {{(NUM_BITS-COUNT_BITS){1'b0}}, r_edge_q} *
                                {{(NUM_BITS-RANK_BITS){1'b0}}, r_rank_q};
                    div_denom = r_csum_q;
                    div_start = (r_edge_q != '0);
                    n_term    = '0;
                end else begin
                    div_start = 1'b1;
                end
            end
            S_PW_DIV: begin
                if (div_done) begin
                    n_term = div_quot;
                end
            end
            S_PW_ACC: begin
                if (col_last) begin
                    rank_we = 1'b1;
                    n_acc   = '0;
                    n_col   = '0;
                    if (row_last) begin
                        n_row  = '0;
                        n_bank = ~r_bank;
                        n_iter = r_iter - 10'd1;
                    end else begin
                        n_row = r_row + 6'd1;
                    end
                end else begin
                    n_acc = acc_sat;
                    n_col = r_col + 6'd1;
                end
            end
            S_SEL_RD: begin
                rank_raddr = {r_bank, r_row};
            end
            S_SEL_CMP: begin
                // Strict compare keeps the lower index on a tie.
                if (!r_picked[r_row] && (!r_found || r_rank_q > r_best_val)) begin
                    n_found    = 1'b1;
                    n_best_idx = r_row;
                    n_best_val = r_rank_q;
                end
                n_row = row_last ? 6'd0 : r_row + 6'd1;
            end
            S_SEL_OUT: begin
                n_strobe = 1'b1;
                n_result.node_index = r_best_idx;
                n_result.rank_score = r_best_val;
                n_result.is_last    = k_last;
                n_picked[r_best_idx] = 1'b1;
                n_found = 1'b0;
                n_k     = r_k + 7'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
            r_picked <= '0;
            r_found  <= 1'b0;
            r_k      <= '0;
            r_iter   <= '0;
            r_bank   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_strobe <= n_strobe;
            r_picked <= n_picked;
            r_found  <= n_found;
            r_k      <= n_k;
            r_iter   <= n_iter;
            r_bank   <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src      <= n_src;
        r_dst      <= n_dst;
        r_row      <= n_row;
        r_col      <= n_col;
        r_csum     <= n_csum;
        r_acc      <= n_acc;
        r_term     <= n_term;
        r_best_idx <= n_best_idx;
        r_best_val <= n_best_val;
        r_result   <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // The final word of a run is never followed directly by another result.
    a_last_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.is_last |=> !o_strobe)
        else $error("result after the final word of a run");

    // A power round writes only the bank that it is not reading.
    a_bank_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rank_we && r_state == S_PW_ACC |-> rank_waddr[6] != r_bank)
        else $error("rank write hit the bank being read");

    // A clear, add or run word keeps the block busy on the next cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_item.mode == MODE_CLEAR || i_item.mode == MODE_ADD ||
                   i_item.mode == MODE_RUN) |=> busy)
        else $error("accepted word did not start work");

    // Results appear only as the selection step hands them out.
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_SEL_OUT))
        else $error("result strobe outside selection");

endmodule

### rtl/pr_div.sv
// Restoring divider: one quotient bit per cycle.
// Depends on pr_pkg. The quotient must fit in RANK_BITS bits.
module pr_div
    import pr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [NUM_BITS-1:0]  i_numer,
    input  logic [SUM_BITS-1:0]  i_denom,
    output logic                 o_done,
    output logic [RANK_BITS-1:0] o_quot
);

    logic [SUM_BITS-1:0]  r_rem;
    logic [RANK_BITS-1:0] r_q;
    logic [SUM_BITS-1:0]  r_den;
    logic [5:0]           r_cnt;
    logic                 r_done;
    logic [SUM_BITS:0]    rem_sh;
    logic                 ge;
    logic [SUM_BITS:0]    diff;

    always_comb begin
        rem_sh = {r_rem, r_q[RANK_BITS-1]};
        ge     = (rem_sh >= {1'b0, r_den});
        diff   = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 6'd0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= 6'd32;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == 6'd1);
            if (r_cnt != 6'd0) begin
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {{(SUM_BITS-COUNT_BITS){1'b0}}, i_numer[NUM_BITS-1:RANK_BITS]};
            r_q   <= i_numer[RANK_BITS-1:0];
            r_den <= i_denom;
        end else if (r_cnt != 6'd0) begin
            r_rem <= ge ? diff[SUM_BITS-1:0] : rem_sh[SUM_BITS-1:0];
            r_q   <= {r_q[RANK_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
